[rtl/core/hcm_pkg.sv]
// Shared types, constants and mod-30 helpers for the 3x3 Hill cipher unit.
// No dependencies; every module file imports this package.
package hcm_pkg;

  // Alphabet size and the reciprocal used for reduction mod 30.
  localparam int unsigned Alphabet = 30;
  localparam int unsigned Recip30  = 1092;  // floor(2^15 / 30)
  localparam int unsigned KeySettle = 4;    // determinant pipeline depth

  typedef logic [4:0] sym_t;
  typedef logic [1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CfgKeyRow0 = 2'd0;
  localparam cfg_idx_t CfgKeyRow1 = 2'd1;
  localparam cfg_idx_t CfgKeyRow2 = 2'd2;
  localparam cfg_idx_t CfgPad     = 2'd3;

  // Reduced key matrix, indexed [row][col].
  typedef logic [2:0][2:0][4:0] key_mat_t;

  // One complete triple of plaintext symbols.
  typedef struct packed {
    sym_t v2;
    sym_t v1;
    sym_t v0;
  } triple_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Key status seen by the front and the output.
  typedef struct packed {
    logic settled;
    logic ok;
  } key_stat_t;

  // Reduce a 5-bit value mod 30.
  function automatic sym_t red5(input sym_t e);
    begin
      red5 = (e >= sym_t'(Alphabet)) ? e - sym_t'(Alphabet) : e;
    end
  endfunction

  // Reduce a 12-bit value mod 30: reciprocal estimate, then one correction.
  function automatic sym_t mod30(input logic [11:0] x);
    logic [22:0] prod;
    logic [7:0]  q;
    logic [11:0] r;
    begin
      prod = 23'(x) * 23'(Recip30);
      q    = prod[22:15];
      r    = x - 12'({4'b0, q} * 12'(Alphabet));
      if (r >= 12'(Alphabet)) begin
        r = r - 12'(Alphabet);
      end
      mod30 = r[4:0];
    end
  endfunction

endpackage

[rtl/core/hcm_in_if.sv]
// Input symbol channel: valid/ready handshake with plaintext symbol payload.
// No dependencies.
interface hcm_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] plain_symbol;
  logic       end_of_text;

  modport source (output valid, output plain_symbol, output end_of_text, input ready);
  modport sink   (input valid, input plain_symbol, input end_of_text, output ready);
endinterface

[rtl/core/hcm_out_if.sv]
// Result channel: valid/ready handshake with cipher symbol payload.
// No dependencies.
interface hcm_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] cipher_symbol;
  logic       last_of_triple;
  logic       key_ok;

  modport source (output valid, output cipher_symbol, output last_of_triple,
                  output key_ok, input ready);
  modport sink   (input valid, input cipher_symbol, input last_of_triple,
                  input key_ok, output ready);
endinterface

[rtl/core/hcm_keyreg.sv]
// Configuration registers, reduced key matrix and pipelined key check.
// Depends on hcm_pkg.
module hcm_keyreg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  hcm_pkg::cfg_idx_t cfg_index,
  input  logic [14:0]       cfg_wdata,
  output hcm_pkg::key_mat_t key,
  output hcm_pkg::sym_t     pad,
  output hcm_pkg::key_stat_t kstat
);
  import hcm_pkg::*;

  logic [2:0][14:0] row_r;
  sym_t             pad_r;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [2:0][9:0]  p_r, q_r;
  sym_t [2:0]       cof_r;
  logic [2:0][9:0]  t_r;
  logic             ok_r, ok_nxt;
  sym_t             det;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= 15'd1;
      row_r[1] <= 15'd32;
      row_r[2] <= 15'd1024;
      pad_r    <= 5'd23;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgKeyRow0: row_r[0] <= cfg_wdata;
        CfgKeyRow1: row_r[1] <= cfg_wdata;
        CfgKeyRow2: row_r[2] <= cfg_wdata;
        CfgPad:     pad_r    <= cfg_wdata[4:0];
        default:    pad_r    <= pad_r;
      endcase
    end
  end

  // Reduced key entries
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        key[r][c] = red5(row_r[r][5*c +: 5]);
      end
    end
  end

  assign pad = pad_r;

  // Settle counter: hold off input until the determinant pipe reflects the key
  always_comb begin
    cnt_nxt = cnt_r;
    if (cfg_we) begin
      cnt_nxt = 3'(KeySettle);
    end else if (cnt_r != 3'd0) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'(KeySettle);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Stage 1: 2x2 minor products
  always_ff @(posedge clk) begin
    p_r[0] <= 10'(key[1][1]) * 10'(key[2][2]);
    q_r[0] <= 10'(key[2][1]) * 10'(key[1][2]);
    p_r[1] <= 10'(key[1][0]) * 10'(key[2][2]);
    q_r[1] <= 10'(key[2][0]) * 10'(key[1][2]);
    p_r[2] <= 10'(key[1][0]) * 10'(key[2][1]);
    q_r[2] <= 10'(key[2][0]) * 10'(key[1][1]);
  end

  // Stage 2: minors mod 30 (offset keeps the difference positive)
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cof_r[i] <= mod30(12'(p_r[i]) + 12'(Alphabet * Alphabet) - 12'(q_r[i]));
    end
  end

  // Stage 3: first-row expansion terms
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= 10'(key[0][i]) * 10'(cof_r[i]);
    end
  end

  // Stage 4: determinant and unit test mod 30
  always_comb begin
    det    = mod30(12'(t_r[0]) + 12'(t_r[2]) + 12'(Alphabet * Alphabet) - 12'(t_r[1]));
    ok_nxt = det inside {5'd1, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b1;
    end else begin
      ok_r <= ok_nxt;
    end
  end

  assign kstat.settled = (cnt_r == 3'd0);
  assign kstat.ok      = ok_r;

endmodule

[rtl/core/hcm_front.sv]
// Front end: accepts plaintext symbols, holds partial triples, pads on end of text.
// Depends on hcm_pkg and hcm_in_if.
module hcm_front (
  input  logic               clk,
  input  logic               rst_n,
  hcm_in_if.sink             in_sym,
  input  hcm_pkg::sym_t      pad,
  input  hcm_pkg::key_stat_t kstat,
  input  hcm_pkg::q_stat_t   qstat,
  output logic               push,
  output hcm_pkg::triple_t   push_data
);
  import hcm_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  sym_t       held0_r, held0_nxt;
  sym_t       held1_r, held1_nxt;
  logic       acc;
  sym_t       sym;
  logic       eot;

  assign in_sym.ready = kstat.settled && !qstat.full;
  assign acc = in_sym.valid && in_sym.ready;
  assign sym = in_sym.plain_symbol;
  assign eot = in_sym.end_of_text;

  // Triple assembly
  always_comb begin
    pos_nxt   = pos_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    push      = 1'b0;
    push_data = '{v0: sym, v1: pad, v2: pad};
    if (acc) begin
      case (pos_r)
        2'd0: begin
          if (eot) begin
            push = 1'b1;
          end else begin
            held0_nxt = sym;
            pos_nxt   = 2'd1;
          end
        end
        2'd1: begin
          push_data = '{v0: held0_r, v1: sym, v2: pad};
          if (eot) begin
            push    = 1'b1;
            pos_nxt = 2'd0;
          end else begin
            held1_nxt = sym;
            pos_nxt   = 2'd2;
          end
        end
        2'd2: begin
          push_data = '{v0: held0_r, v1: held1_r, v2: sym};
          push      = 1'b1;
          pos_nxt   = 2'd0;
        end
        default: begin
          pos_nxt = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      held0_r <= '0;
      held1_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule

[rtl/core/hcm_queue.sv]
// Two-entry triple queue between front and back end.
// Depends on hcm_pkg.
module hcm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hcm_pkg::triple_t push_data,
  input  logic             pop,
  output hcm_pkg::triple_t head,
  output hcm_pkg::q_stat_t qstat
);
  import hcm_pkg::*;

  triple_t    mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rd_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

[rtl/core/hcm_back.sv]
// Back end: one column per cycle unless stalled; dot product, mod-30 output reg.
// Depends on hcm_pkg and hcm_out_if.
module hcm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hcm_pkg::triple_t   head,
  input  hcm_pkg::q_stat_t   qstat,
  input  hcm_pkg::key_mat_t  key,
  input  hcm_pkg::key_stat_t kstat,
  output logic               pop,
  hcm_out_if.source          out_res
);
  import hcm_pkg::*;

  logic [1:0]  col_r, col_nxt;
  logic        s1_v_r, s1_v_nxt;
  logic [11:0] s1_sum_r;
  logic        s1_last_r;
  logic        out_v_r, out_v_nxt;
  sym_t        out_sym_r;
  logic        out_last_r;
  logic        adv, issue;
  logic [11:0] sum;
  sym_t        k0, k1, k2;

  // Pipeline advances when the output register is free or being taken
  assign adv   = !out_v_r || out_res.ready;
  assign issue = adv && !qstat.empty;
  assign pop   = issue && (col_r == 2'd2);

  // Key column for the current result
  always_comb begin
    k0 = key[0][0];
    k1 = key[1][0];
    k2 = key[2][0];
    case (col_r)
      2'd1: begin
        k0 = key[0][1];
        k1 = key[1][1];
        k2 = key[2][1];
      end
      2'd2: begin
        k0 = key[0][2];
        k1 = key[1][2];
        k2 = key[2][2];
      end
      default: begin
        k0 = key[0][0];
        k1 = key[1][0];
        k2 = key[2][0];
      end
    endcase
    sum = 12'(10'(head.v0) * 10'(k0)) + 12'(10'(head.v1) * 10'(k1))
        + 12'(10'(head.v2) * 10'(k2));
  end

  // Control next state
  always_comb begin
    col_nxt   = col_r;
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (adv) begin
      s1_v_nxt  = issue;
      out_v_nxt = s1_v_r;
      if (issue) begin
        col_nxt = (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= 2'd0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r   <= sum;
      s1_last_r  <= (col_r == 2'd2);
      out_sym_r  <= mod30(s1_sum_r);
      out_last_r <= s1_last_r;
    end
  end

  assign out_res.valid          = out_v_r;
  assign out_res.cipher_symbol  = out_sym_r;
  assign out_res.last_of_triple = out_last_r;
  assign out_res.key_ok         = kstat.ok;

endmodule

[rtl/core/hill_cipher_3x3_mod30_unit.sv]
// Top level of the 3x3 Hill cipher over a 30-symbol alphabet.
// Depends on hcm_pkg, hcm_in_if, hcm_out_if, hcm_keyreg, hcm_front, hcm_queue, hcm_back.
//
//   channel   dir  handshake          payload
//   in_sym    in   valid/ready        plain_symbol[4:0], end_of_text
//   out_res   out  valid/ready        cipher_symbol[4:0], last_of_triple, key_ok
//   cfg_*     in   cfg_we (no stall)  cfg_index[1:0], cfg_wdata[14:0]
//
// One symbol is accepted per cycle while the key is settled and the queue has room;
// each completed triple yields three words, one per cycle unless the output stalls,
// through the dot-product and mod-30 output registers. A padded triple from end of
// text still yields three words, so the two-entry queue stalls the input when such
// triples come faster than the back end drains them. Reset is synchronous; after reset
// and any config write the input waits until the determinant pipe refreshes key_ok.
// Output backpressure freezes the back end only; the front keeps filling the queue.
module hill_cipher_3x3_mod30_unit (
  input  logic              clk,
  input  logic              rst_n,
  hcm_in_if.sink            in_sym,
  hcm_out_if.source         out_res,
  input  logic              cfg_we,
  input  hcm_pkg::cfg_idx_t cfg_index,
  input  logic [14:0]       cfg_wdata
);
  import hcm_pkg::*;

  key_mat_t  key;
  sym_t      pad;
  key_stat_t kstat;
  q_stat_t   qstat;
  logic      push, pop;
  triple_t   push_data, head;

  hcm_keyreg u_keyreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key       (key),
    .pad       (pad),
    .kstat     (kstat)
  );

  hcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sym    (in_sym),
    .pad       (pad),
    .kstat     (kstat),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  hcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  hcm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .qstat   (qstat),
    .key     (key),
    .kstat   (kstat),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule
